### rtl/core/qrs_pkg.sv
// shared types and constants of the quadratic root solver
package qrs_pkg;

   // fixed field widths
   localparam int COEF_WIDTH = 16;
   localparam int ROOT_WIDTH = 36;
   localparam int COUNT_WIDTH = 2;

   // root count codes
   localparam logic [COUNT_WIDTH-1:0] CNT_NONE = 2'd0;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = 2'd1;
   localparam logic [COUNT_WIDTH-1:0] CNT_TWO  = 2'd2;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] coef_quad;
      logic signed [COEF_WIDTH-1:0] coef_lin;
      logic signed [COEF_WIDTH-1:0] coef_const;
   } req_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]       root_count;
      logic signed [ROOT_WIDTH-1:0] first_root;
      logic signed [ROOT_WIDTH-1:0] second_root;
   } rsp_type;

endpackage

### rtl/core/qrs_sqrt_cell.sv
// one digit step of the pipelined square root row
module qrs_sqrt_cell
   import qrs_pkg::*;
#(
   parameter int RAD_W  = 4,
   parameter int ROOT_W = 2,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [ROOT_W-1:0] in_root,
   input  logic [ROOT_W+2:0] in_rem,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RAD_W-1:0]  out_rad,
   output logic [ROOT_W-1:0] out_root,
   output logic [ROOT_W+2:0] out_rem,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+2:0] rem_ff, rem_in;
   logic [SIDE_W-1:0] side_ff;
   logic [ROOT_W+2:0] rem_sh, trial;

   // bring down the next bit pair and try the next root bit
   always_comb begin
      rem_sh = {in_rem[ROOT_W:0], in_rad[RAD_W-1 -: 2]};
      trial  = {1'b0, in_root, 2'b01};
      rad_in = {in_rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {in_root[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {in_root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_root  = root_ff;
   assign out_rem   = rem_ff;
   assign out_side  = side_ff;

endmodule

### rtl/core/qrs_div_cell.sv
// one quotient bit step of the pipelined restoring divider row
module qrs_div_cell
   import qrs_pkg::*;
#(
   parameter int NUM_W  = 2,
   parameter int DEN_W  = 2,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_nq,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_nq,
   output logic [DEN_W-1:0]  out_rem,
   output logic [DEN_W-1:0]  out_den,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff;
   logic [NUM_W-1:0]  nq_ff, nq_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [DEN_W-1:0]  part;

   // shift in the next numerator bit, quotient bit shifts in at the bottom
   always_comb begin
      part = {in_rem[DEN_W-2:0], in_nq[NUM_W-1]};
      if (part >= in_den) begin
         rem_in = part - in_den;
         nq_in  = {in_nq[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = part;
         nq_in  = {in_nq[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         nq_ff   <= nq_in;
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_nq    = nq_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

### rtl/core/quadratic_root_solver.sv
// quadratic root solver top level: front end, square root row, divider rows, output skid
//
// usage
// - req channel carries coefficients a, b, c; rsp channel carries the root count
//   and two signed roots with FRAC_BITS fraction bits
// - a transfer happens when valid is high and stall is low
// - the pipeline holds one square root cell per root bit and one divider cell per
//   quotient bit, plus six stages of coefficient capture, products, discriminant,
//   numerators, magnitudes and output
// - throughput is one item per cycle while not stalled; every cell hands its item on
// - a two-entry output (result register plus skid register) lets the pipeline keep
//   taking items while a result waits; req_stall rises only when both are full,
//   and then the whole pipeline holds
// - reset clears all valid bits; no item is in flight afterwards
// - a zero linear and quadratic coefficient gives no root, count zero
module quadratic_root_solver
   import qrs_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   localparam int W      = COEF_WIDTH;
   localparam int NS     = W + 1 + FRAC_BITS;
   localparam int RAD_W  = 2 * NS;
   localparam int D_W    = 2 * W + 2;
   localparam int DISC_W = 2 * W + 3;
   localparam int NW     = W + FRAC_BITS + 2;
   localparam int DEN_W  = W + 1;
   localparam int EXT_W  = (NW + 1 > ROOT_WIDTH) ? NW + 1 : ROOT_WIDTH;
   localparam int SQ_SIDE_W = COUNT_WIDTH + 3 * W;
   localparam int DV_SIDE_W = COUNT_WIDTH + 1;

   logic advance;

   // front stage: coefficient capture
   logic                s1_valid_ff;
   logic signed [W-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   logic signed [2*W-1:0] bb_in, ac_in;

   // products
   logic                  s2_valid_ff;
   logic signed [2*W-1:0] s2_bb_ff, s2_ac_ff;
   logic signed [W-1:0]   s2_a_ff, s2_b_ff, s2_c_ff;
   logic signed [DISC_W-1:0] disc;
   logic [COUNT_WIDTH-1:0]   cnt_in;
   logic [D_W-1:0]           d_in;

   // discriminant and classification
   logic                   s3_valid_ff;
   logic [COUNT_WIDTH-1:0] s3_cnt_ff;
   logic [D_W-1:0]         s3_d_ff;
   logic signed [W-1:0]    s3_a_ff, s3_b_ff, s3_c_ff;

   // square root row
   logic                 sq_valid [0:NS];
   logic [RAD_W-1:0]     sq_rad   [0:NS];
   logic [NS-1:0]        sq_root  [0:NS];
   logic [NS+2:0]        sq_rem   [0:NS];
   logic [SQ_SIDE_W-1:0] sq_side  [0:NS];

   // numerators
   logic [COUNT_WIDTH-1:0] sq_cnt;
   logic signed [W-1:0]    sq_a, sq_b, sq_c;
   logic signed [NW:0]     b_scaled, c_scaled, s_ext, n1_in, n2_in;
   logic signed [DEN_W-1:0] den_in;
   logic                    s4_valid_ff;
   logic [COUNT_WIDTH-1:0]  s4_cnt_ff;
   logic signed [NW:0]      s4_n1_ff, s4_n2_ff;
   logic signed [DEN_W-1:0] s4_den_ff;

   // magnitudes and signs
   logic [NW:0]            mag1_full, mag2_full;
   logic [DEN_W-1:0]       den_mag;
   logic                   s5_valid_ff;
   logic [COUNT_WIDTH-1:0] s5_cnt_ff;
   logic [NW-1:0]          s5_mag1_ff, s5_mag2_ff;
   logic [DEN_W-1:0]       s5_den_ff;
   logic                   s5_neg1_ff, s5_neg2_ff;

   // divider rows
   logic                 dv1_valid [0:NW];
   logic [NW-1:0]        dv1_nq    [0:NW];
   logic [DEN_W-1:0]     dv1_rem   [0:NW];
   logic [DEN_W-1:0]     dv1_den   [0:NW];
   logic [DV_SIDE_W-1:0] dv1_side  [0:NW];
   logic                 dv2_valid [0:NW];
   logic [NW-1:0]        dv2_nq    [0:NW];
   logic [DEN_W-1:0]     dv2_rem   [0:NW];
   logic [DEN_W-1:0]     dv2_den   [0:NW];
   logic [0:0]           dv2_side  [0:NW];

   // result and output buffering
   logic [COUNT_WIDTH-1:0] out_cnt;
   logic signed [NW:0]     q1_signed, q2_signed;
   logic signed [EXT_W-1:0] q1_ext, q2_ext;
   rsp_type                result;
   logic                   result_valid;
   logic                   rsp_valid_ff, skid_valid_ff;
   rsp_type                rsp_ff, skid_ff;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // coefficient capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_a_ff <= req.coef_quad;
         s1_b_ff <= req.coef_lin;
         s1_c_ff <= req.coef_const;
      end
   end

   // b squared and a times c
   always_comb begin
      bb_in = s1_b_ff * s1_b_ff;
      ac_in = s1_a_ff * s1_c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_bb_ff <= bb_in;
         s2_ac_ff <= ac_in;
         s2_a_ff  <= s1_a_ff;
         s2_b_ff  <= s1_b_ff;
         s2_c_ff  <= s1_c_ff;
      end
   end

   // discriminant and root count
   always_comb begin
      disc = DISC_W'(s2_bb_ff) - (DISC_W'(s2_ac_ff) <<< 2);
      d_in = '0;
      if (s2_a_ff == '0) begin
         cnt_in = (s2_b_ff != '0) ? CNT_ONE : CNT_NONE;
      end else if (disc == '0) begin
         cnt_in = CNT_ONE;
      end else if (!disc[DISC_W-1]) begin
         cnt_in = CNT_TWO;
         d_in   = disc[D_W-1:0];
      end else begin
         cnt_in = CNT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_cnt_ff <= cnt_in;
         s3_d_ff   <= d_in;
         s3_a_ff   <= s2_a_ff;
         s3_b_ff   <= s2_b_ff;
         s3_c_ff   <= s2_c_ff;
      end
   end

   // square root row, one root bit per cell
   assign sq_valid[0] = s3_valid_ff;
   assign sq_rad[0]   = RAD_W'(s3_d_ff) << (2 * FRAC_BITS);
   assign sq_root[0]  = '0;
   assign sq_rem[0]   = '0;
   assign sq_side[0]  = {s3_cnt_ff, s3_a_ff, s3_b_ff, s3_c_ff};

   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      qrs_sqrt_cell #(
         .RAD_W  (RAD_W),
         .ROOT_W (NS),
         .SIDE_W (SQ_SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (sq_valid[i]),
         .in_rad    (sq_rad[i]),
         .in_root   (sq_root[i]),
         .in_rem    (sq_rem[i]),
         .in_side   (sq_side[i]),
         .out_valid (sq_valid[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_root  (sq_root[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_side  (sq_side[i+1])
      );
   end

   // signed numerators and denominator
   always_comb begin
      sq_cnt   = sq_side[NS][SQ_SIDE_W-1 -: COUNT_WIDTH];
      sq_a     = sq_side[NS][3*W-1 -: W];
      sq_b     = sq_side[NS][2*W-1 -: W];
      sq_c     = sq_side[NS][W-1:0];
      b_scaled = (NW+1)'(sq_b) <<< FRAC_BITS;
      c_scaled = (NW+1)'(sq_c) <<< FRAC_BITS;
      s_ext    = signed'((NW+1)'(sq_root[NS]));
      if (sq_a == '0) begin
         n1_in  = -c_scaled;
         n2_in  = -c_scaled;
         den_in = DEN_W'(sq_b);
      end else begin
         n1_in  = s_ext - b_scaled;
         n2_in  = -b_scaled - s_ext;
         den_in = DEN_W'(sq_a) <<< 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= sq_valid[NS];
      end
      if (advance) begin
         s4_cnt_ff <= sq_cnt;
         s4_n1_ff  <= n1_in;
         s4_n2_ff  <= n2_in;
         s4_den_ff <= den_in;
      end
   end

   // magnitudes and quotient signs
   always_comb begin
      mag1_full = s4_n1_ff[NW] ? -s4_n1_ff : s4_n1_ff;
      mag2_full = s4_n2_ff[NW] ? -s4_n2_ff : s4_n2_ff;
      den_mag   = s4_den_ff[DEN_W-1] ? -s4_den_ff : s4_den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s5_cnt_ff  <= s4_cnt_ff;
         s5_mag1_ff <= mag1_full[NW-1:0];
         s5_mag2_ff <= mag2_full[NW-1:0];
         s5_den_ff  <= den_mag;
         s5_neg1_ff <= s4_n1_ff[NW] ^ s4_den_ff[DEN_W-1];
         s5_neg2_ff <= s4_n2_ff[NW] ^ s4_den_ff[DEN_W-1];
      end
   end

   // two divider rows, one quotient bit per cell
   assign dv1_valid[0] = s5_valid_ff;
   assign dv1_nq[0]    = s5_mag1_ff;
   assign dv1_rem[0]   = '0;
   assign dv1_den[0]   = s5_den_ff;
   assign dv1_side[0]  = {s5_cnt_ff, s5_neg1_ff};
   assign dv2_valid[0] = s5_valid_ff;
   assign dv2_nq[0]    = s5_mag2_ff;
   assign dv2_rem[0]   = '0;
   assign dv2_den[0]   = s5_den_ff;
   assign dv2_side[0]  = s5_neg2_ff;

   for (genvar i = 0; i < NW; i++) begin : g_div
      qrs_div_cell #(
         .NUM_W  (NW),
         .DEN_W  (DEN_W),
         .SIDE_W (DV_SIDE_W)
      ) u_plus (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv1_valid[i]),
         .in_nq     (dv1_nq[i]),
         .in_rem    (dv1_rem[i]),
         .in_den    (dv1_den[i]),
         .in_side   (dv1_side[i]),
         .out_valid (dv1_valid[i+1]),
         .out_nq    (dv1_nq[i+1]),
         .out_rem   (dv1_rem[i+1]),
         .out_den   (dv1_den[i+1]),
         .out_side  (dv1_side[i+1])
      );
      qrs_div_cell #(
         .NUM_W  (NW),
         .DEN_W  (DEN_W),
         .SIDE_W (1)
      ) u_minus (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv2_valid[i]),
         .in_nq     (dv2_nq[i]),
         .in_rem    (dv2_rem[i]),
         .in_den    (dv2_den[i]),
         .in_side   (dv2_side[i]),
         .out_valid (dv2_valid[i+1]),
         .out_nq    (dv2_nq[i+1]),
         .out_rem   (dv2_rem[i+1]),
         .out_den   (dv2_den[i+1]),
         .out_side  (dv2_side[i+1])
      );
   end

   // apply signs and mask unused roots
   always_comb begin
      out_cnt   = dv1_side[NW][DV_SIDE_W-1 -: COUNT_WIDTH];
      q1_signed = signed'({1'b0, dv1_nq[NW]});
      q2_signed = signed'({1'b0, dv2_nq[NW]});
      if (dv1_side[NW][0]) begin
         q1_signed = -q1_signed;
      end
      if (dv2_side[NW][0]) begin
         q2_signed = -q2_signed;
      end
      q1_ext = EXT_W'(q1_signed);
      q2_ext = EXT_W'(q2_signed);
      result.root_count  = out_cnt;
      result.first_root  = (out_cnt == CNT_NONE) ? '0 : q1_ext[ROOT_WIDTH-1:0];
      result.second_root = (out_cnt == CNT_TWO) ? q2_ext[ROOT_WIDTH-1:0] : '0;
      result_valid = dv1_valid[NW] && dv2_valid[NW] && advance;
   end

   // result register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && rsp_stall) begin
         if (result_valid) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_ff        <= skid_ff;
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= result_valid;
         if (result_valid) begin
            rsp_ff <= result;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while result register is empty");

   a_no_root_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.root_count == CNT_NONE) |->
         (rsp.first_root == '0 && rsp.second_root == '0))
      else $error("roots not cleared for empty result");

   a_count_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.root_count == CNT_NONE || rsp.root_count == CNT_ONE ||
                     rsp.root_count == CNT_TWO))
      else $error("root count out of range");

   a_single_root: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.root_count == CNT_ONE) |-> rsp.second_root == '0)
      else $error("second root set for single root result");
`endif

endmodule

### tb/quadratic_root_solver_test.sv
// testbench of the quadratic root solver: directed table, random coefficients, scoreboard
`timescale 1ns / 100ps

module quadratic_root_solver_test;
   import qrs_pkg::*;

   localparam int FRAC = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 2 * FRAC + 60;
   localparam int RANDOM_ITEMS = 1530;
   localparam int HOLD_AFTER = 330;
   localparam int HOLD_CYCLES = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   rsp_type expected_roots[$];
   int      fail_count = 0;
   int      idle_cycles = 0;
   bit      quiet = 1'b0;

   typedef struct {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      bit                 typed;
      rsp_type            want;
   } table_row;

   quadratic_root_solver #(.FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
   );

   always #2 clock = ~clock;

   // floor(sqrt(d * 2^(2*FRAC))) by restoring digit recurrence
   function automatic logic [47:0] disc_root(longint unsigned d);
      logic [95:0] x;
      logic [97:0] rem;
      logic [97:0] trial;
      logic [47:0] root;
      x = 96'(d) << (2 * FRAC);
      rem = '0;
      root = '0;
      for (int i = 47; i >= 0; i--) begin
         rem = (rem << 2) | 98'(x[2*i +: 2]);
         trial = (98'(root) << 2) | 98'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 48'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   // expected roots of one coefficient set
   function automatic rsp_type solve_roots(req_type r);
      longint a, b, c, disc, den, s, scale;
      rsp_type o;
      a = r.coef_quad;
      b = r.coef_lin;
      c = r.coef_const;
      scale = longint'(1) << FRAC;
      o = '0;
      o.root_count = CNT_NONE;
      if (a == 0) begin
         if (b != 0) begin
            o.first_root = ROOT_WIDTH'((-c * scale) / b);
            o.root_count = CNT_ONE;
         end
      end else begin
         disc = b * b - 4 * a * c;
         den = 2 * a;
         if (disc > 0) begin
            s = longint'(disc_root(disc));
            o.first_root = ROOT_WIDTH'((-b * scale + s) / den);
            o.second_root = ROOT_WIDTH'((-b * scale - s) / den);
            o.root_count = CNT_TWO;
         end else if (disc == 0) begin
            o.first_root = ROOT_WIDTH'((-b * scale) / den);
            o.root_count = CNT_ONE;
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // offer one coefficient set and hold it until the transfer
   task automatic send_coefs(req_type r, rsp_type want);
      req_valid <= 1'b1;
      req <= r;
      do @(posedge clock); while (req_stall);
      expected_roots.push_back(want);
   endtask

   // random gap on the sender side
   task automatic sender_gap();
      int n;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic req_type random_coefs();
      req_type r;
      int k, m;
      r.coef_quad = 16'($urandom);
      r.coef_lin = 16'($urandom);
      r.coef_const = 16'($urandom);
      case ($urandom_range(0, 9))
         0: r.coef_quad = '0;
         1: begin
            r.coef_quad = '0;
            r.coef_lin = 16'($signed($urandom_range(0, 6)) - 3);
         end
         2, 3: begin
            r.coef_quad = 16'($signed($urandom_range(0, 40)) - 20);
            r.coef_lin = 16'($signed($urandom_range(0, 200)) - 100);
            r.coef_const = 16'($signed($urandom_range(0, 200)) - 100);
         end
         4: begin
            // perfect square, zero discriminant
            k = $urandom_range(1, 60) * ($urandom_range(0, 1) ? 1 : -1);
            m = int'($urandom_range(0, 40)) - 20;
            r.coef_quad = 16'(k);
            r.coef_lin = 16'(2 * k * m);
            r.coef_const = 16'(k * m * m);
         end
         5: r.coef_quad = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: ;
      endcase
      return r;
   endfunction

   // receiver stall: random bursts plus one long hold after a number of transfers
   always @(posedge clock) begin
      static int burst = 0;
      static int hold_left = 0;
      static int accepted = 0;
      logic next_stall;
      next_stall = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         accepted++;
         if (accepted == HOLD_AFTER)
            hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else if (burst > 0) begin
         burst--;
         next_stall = 1'b1;
      end else if (!quiet && !reset && $urandom_range(0, 9) == 0) begin
         burst = $urandom_range(0, 9);
         next_stall = 1'b1;
      end
      rsp_stall <= next_stall;
   end

   // scoreboard on each result transfer
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_roots.size() == 0) begin
            $display("unexpected result transfer at %0t", $time);
            fail_count++;
         end else begin
            want = expected_roots.pop_front();
            if (rsp.root_count !== want.root_count)
               report_mismatch("root_count", rsp.root_count, want.root_count);
            if (rsp.first_root !== want.first_root)
               report_mismatch("first_root", rsp.first_root, want.first_root);
            if (rsp.second_root !== want.second_root)
               report_mismatch("second_root", rsp.second_root, want.second_root);
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      table_row rows[$];
      req_type r;
      rsp_type z;
      z = '0;
      rows = '{
         '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{CNT_NONE, 36'sd0, 36'sd0}},
         '{16'sd0, 16'sd0, 16'sd5, 1'b1, '{CNT_NONE, 36'sd0, 36'sd0}},
         '{16'sd0, 16'sd1, 16'sd0, 1'b1, '{CNT_ONE, 36'sd0, 36'sd0}},
         '{16'sd0, 16'sd1, -16'sd1, 1'b1, '{CNT_ONE, 36'sd65536, 36'sd0}},
         '{16'sd1, 16'sd0, 16'sd1, 1'b1, '{CNT_NONE, 36'sd0, 36'sd0}},
         '{16'sd1, 16'sd2, 16'sd1, 1'b1, '{CNT_ONE, -36'sd65536, 36'sd0}},
         '{16'sd1, 16'sd0, -16'sd1, 1'b1, '{CNT_TWO, 36'sd65536, -36'sd65536}},
         '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, z},
         '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, z},
         '{16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, z},
         '{16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, z},
         '{16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, z},
         '{16'sh7fff, 16'sh0, 16'sh8000, 1'b0, z},
         '{16'sh0, 16'sh8000, 16'sh7fff, 1'b0, z},
         '{16'sh0, 16'sh1, 16'sh8000, 1'b0, z},
         '{16'sh0, -16'sh1, 16'sh7fff, 1'b0, z},
         '{16'sh7fff, 16'sh1, 16'sh0, 1'b0, z},
         '{16'sh7fff, 16'sh3, 16'sh0, 1'b0, z},
         '{-16'sh1, 16'sh7fff, 16'sh1, 1'b0, z},
         '{16'sh1, 16'sh8000, 16'sh4000, 1'b0, z},
         '{-16'sh3, 16'sh5, 16'sh7, 1'b0, z},
         '{16'sh8000, 16'sh0, 16'sh0, 1'b0, z}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (rows[i]) begin
         r.coef_quad = rows[i].a;
         r.coef_lin = rows[i].b;
         r.coef_const = rows[i].c;
         send_coefs(r, rows[i].typed ? rows[i].want : solve_roots(r));
         sender_gap();
      end

      // sender pauses until the pipeline is empty
      req_valid <= 1'b0;
      wait (expected_roots.size() == 0);
      @(posedge clock);

      // random coefficient sets
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - 200) quiet = 1'b1;
         r = random_coefs();
         send_coefs(r, solve_roots(r));
         sender_gap();
      end
      req_valid <= 1'b0;

      wait (expected_roots.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
